// File: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Short forms for the concurrent checks used in the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Whenever ante holds, cons must hold in the same cycle.
`define ASSERT_IMPLIES(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("implication check failed");

// The condition must never hold.
`define ASSERT_NEVER(label, clk_sig, rst_sig, cond) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) !(cond)) \
    else $error("forbidden condition seen");

`endif

// File: hdl/qts_pkg.sv
// ---------------------------------------------------------------------------
// qts_pkg
// Types and constants shared by the two-stack queue modules.
// ---------------------------------------------------------------------------
package qts_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int CAP_W         = 5;
  localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;
  localparam int QUEUE_DEPTH   = 2;
  localparam int PADDR_W       = 3;

  // Register index is taken from paddr[2].
  localparam logic REG_CAPACITY = 1'b0;

  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;

  typedef enum logic [1:0] {
    CMD_PUSH,
    CMD_POP,
    CMD_PEEK,
    CMD_NOP
  } cmd_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOVE,
    ST_PEEK
  } back_state_t;

  typedef struct packed {
    logic [1:0]          operation;
    logic signed [31:0]  value;
  } item_t;

  typedef struct packed {
    logic signed [31:0]  front_value;
    logic                queue_empty;
    logic                push_dropped;
  } result_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic signed [31:0]  value;
  } cmd_t;

endpackage

// File: hdl/queue_from_two_stacks.sv
// An accepted item waits in the front queue until the execute side takes it. A push, a
// pop of a non-empty outbox or an unused code then writes the result register directly; a
// peek of a non-empty outbox passes through the peek state first. A refill reads the n inbox
// entries one at a time, lands the last one on the outbox, then uses the refilled outbox.
// No new command is taken until a refill or peek is done; the front queue buffers meanwhile.
// Reset (synchronous, rst high) empties both stacks and the input queue, sets capacity
// to 16; the stack memories need no clearing pass.
// ---------------------------------------------------------------------------
// queue_from_two_stacks
// FIFO of signed words kept in an inbox stack and an outbox stack.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module queue_from_two_stacks import qts_pkg::*; #(
  parameter int MAX_DEPTH = DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  // Input items.
  input  logic               item_valid,
  output logic               item_stall,
  input  item_t              item,
  // Result items.
  output logic               result_valid,
  input  logic               result_stall,
  output result_t            result,
  // Register port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // The capacity register limits how many entries the inbox may hold. Only the
  // low five bits of a write are kept; values above MAX_DEPTH act as MAX_DEPTH.
  logic [CAP_W-1:0] capacity;
  logic             reg_write;

  // Front to back command channel.
  logic cmd_valid;
  cmd_t cmd;
  logic cmd_take;

  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
    end else if (reg_write && paddr[2] == REG_CAPACITY) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  // Writes to any other register index fall on nothing and read back as zero.
  assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(capacity) : '0;

  // The front side decodes items into commands and buffers them, so input keeps flowing,
  // up to that buffer's depth, while the back side walks a refill or awaits a stalled result.
  qts_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_take   (cmd_take)
  );

  // The back side owns both stacks. It only takes a command once its result
  // register is free, so each command completes into an empty slot.
  qts_back #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .capacity     (capacity),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_take     (cmd_take),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // The back side never pulls from an empty command queue.
  `ASSERT_IMPLIES(a_take_needs_cmd, clk, rst, cmd_take, cmd_valid)
  // A command is only started when the result register can take its answer.
  `ASSERT_IMPLIES(a_take_needs_room, clk, rst, cmd_take, !result_valid || !result_stall)
  // A refused push never carries a front value.
  `ASSERT_NEVER(a_drop_no_front, clk, rst, result_valid && result.push_dropped && result.front_value != 32'sd0)
  // A nonzero front value comes only from a peek of a queue that holds entries.
  `ASSERT_NEVER(a_front_not_empty, clk, rst, result_valid && result.front_value != 32'sd0 && result.queue_empty)

endmodule

// File: hdl/qts_front.sv
// ---------------------------------------------------------------------------
// qts_front
// Accepts items, decodes the operation and holds them in a short queue.
// ---------------------------------------------------------------------------
module qts_front import qts_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  output logic  item_stall,
  input  item_t item,
  output logic  cmd_valid,
  output cmd_t  cmd,
  input  logic  cmd_take
);

  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  cmd_t           slots [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QCW-1:0] fill;
  logic           push;
  logic           pop;
  cmd_t           decoded;

  // Turn the raw operation code into a command kind.
  always_comb begin
    decoded.value = item.value;
    unique case (item.operation)
      OP_PUSH: decoded.kind = CMD_PUSH;
      OP_POP:  decoded.kind = CMD_POP;
      OP_PEEK: decoded.kind = CMD_PEEK;
      default: decoded.kind = CMD_NOP;
    endcase
  end

  assign item_stall = (fill == QCW'(QUEUE_DEPTH));
  assign push       = item_valid && !item_stall;
  assign cmd_valid  = (fill != '0);
  assign pop        = cmd_take && cmd_valid;
  assign cmd        = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QAW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QAW'(1);
      end
      if (push && !pop) begin
        fill <= fill + QCW'(1);
      end else if (pop && !push) begin
        fill <= fill - QCW'(1);
      end
    end
  end

endmodule

// File: hdl/qts_back.sv
// ---------------------------------------------------------------------------
// qts_back
// Executes commands on the inbox and outbox stacks and registers the result.
// ---------------------------------------------------------------------------
module qts_back import qts_pkg::*; #(
  parameter int MAX_DEPTH = DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [CAP_W-1:0] capacity,
  input  logic             cmd_valid,
  input  cmd_t             cmd,
  output logic             cmd_take,
  output logic             result_valid,
  input  logic             result_stall,
  output result_t          result
);

  localparam int AW   = $clog2(MAX_DEPTH);
  localparam int CW   = $clog2(MAX_DEPTH + 1);
  localparam int CAPW = (CW > CAP_W) ? CW : CAP_W;

  logic [31:0]    in_mem  [MAX_DEPTH];
  logic [31:0]    out_mem [MAX_DEPTH];
  logic [31:0]    in_rd;
  logic [31:0]    out_rd;

  back_state_t    state;
  back_state_t    state_next;
  logic [CW-1:0]  ic;
  logic [CW-1:0]  ic_next;
  logic [CW-1:0]  oc;
  logic [CW-1:0]  oc_next;
  logic           pend;
  logic           pend_next;
  cmd_kind_t      kind_hold;
  cmd_kind_t      kind_hold_next;

  logic           in_we;
  logic [AW-1:0]  in_raddr;
  logic           out_we;
  logic [AW-1:0]  out_raddr;
  logic           res_we;
  result_t        res_next;

  logic           out_free;
  logic           start;
  logic [CAPW-1:0] cap_ext;
  logic [CAPW-1:0] depth_ext;
  logic [CW-1:0]  eff_cap;

  assign cap_ext   = CAPW'(capacity);
  assign depth_ext = CAPW'(MAX_DEPTH);
  assign eff_cap   = (cap_ext > depth_ext) ? CW'(depth_ext) : CW'(cap_ext);

  assign out_free  = !result_valid || !result_stall;
  assign start     = (state == ST_IDLE) && cmd_valid && out_free;
  assign in_raddr  = AW'(ic - CW'(1));
  assign out_raddr = AW'(oc - CW'(1));

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (cmd.kind == CMD_POP && oc == '0 && ic != '0) begin
            state_next = ST_MOVE;
          end else if (cmd.kind == CMD_PEEK) begin
            if (oc != '0) begin
              state_next = ST_PEEK;
            end else if (ic != '0) begin
              state_next = ST_MOVE;
            end
          end
        end
      end
      ST_MOVE: begin
        if (ic == '0 && !pend) begin
          state_next = (kind_hold == CMD_PEEK) ? ST_PEEK : ST_IDLE;
        end
      end
      ST_PEEK: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath control and result.
  always_comb begin
    cmd_take       = 1'b0;
    in_we          = 1'b0;
    out_we         = 1'b0;
    ic_next        = ic;
    oc_next        = oc;
    pend_next      = 1'b0;
    kind_hold_next = kind_hold;
    res_we         = 1'b0;
    res_next       = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd_take       = 1'b1;
          kind_hold_next = cmd.kind;
          unique case (cmd.kind)
            CMD_PUSH: begin
              res_we = 1'b1;
              if (ic < eff_cap) begin
                in_we   = 1'b1;
                ic_next = ic + CW'(1);
              end else begin
                res_next.push_dropped = 1'b1;
                res_next.queue_empty  = (ic == '0) && (oc == '0);
              end
            end
            CMD_POP: begin
              if (oc != '0) begin
                oc_next              = oc - CW'(1);
                res_we               = 1'b1;
                res_next.queue_empty = (ic == '0) && (oc == CW'(1));
              end else if (ic == '0) begin
                res_we               = 1'b1;
                res_next.queue_empty = 1'b1;
              end
            end
            CMD_PEEK: begin
              if (oc == '0 && ic == '0) begin
                res_we               = 1'b1;
                res_next.queue_empty = 1'b1;
              end
            end
            CMD_NOP: begin
              res_we               = 1'b1;
              res_next.queue_empty = (ic == '0) && (oc == '0);
            end
            default: ;
          endcase
        end
      end
      ST_MOVE: begin
        // Read the inbox top into in_rd, and land in_rd on the outbox while pend is set.
        if (ic != '0) begin
          ic_next   = ic - CW'(1);
          pend_next = 1'b1;
        end
        if (pend) begin
          out_we  = 1'b1;
          oc_next = oc + CW'(1);
        end
        if (ic == '0 && !pend && kind_hold == CMD_POP) begin
          oc_next              = oc - CW'(1);
          res_we               = 1'b1;
          res_next.queue_empty = (oc == CW'(1));
        end
      end
      ST_PEEK: begin
        res_we               = 1'b1;
        res_next.front_value = out_rd;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_we) begin
      in_mem[ic[AW-1:0]] <= cmd.value;
    end
    in_rd <= in_mem[in_raddr];
  end

  always_ff @(posedge clk) begin
    if (out_we) begin
      out_mem[oc[AW-1:0]] <= in_rd;
    end
    out_rd <= out_mem[out_raddr];
  end

  always_ff @(posedge clk) begin
    if (res_we) begin
      result <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      ic           <= '0;
      oc           <= '0;
      pend         <= 1'b0;
      kind_hold    <= CMD_NOP;
      result_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ic        <= ic_next;
      oc        <= oc_next;
      pend      <= pend_next;
      kind_hold <= kind_hold_next;
      if (res_we) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

// File: test/queue_from_two_stacks_tb.sv
// ---------------------------------------------------------------------------
// queue_from_two_stacks_tb
// Self-checking bench for the two-stack queue. It mirrors both stacks and the
// capacity register to predict every result item, and compares each one
// field by field as it leaves the block. The stimulus runs through several
// capacity settings under random back-pressure on both sides.
// ---------------------------------------------------------------------------
module queue_from_two_stacks_tb;
  import qts_pkg::*;

  localparam int DEPTH = DEPTH_DEFAULT;

  // The register port decodes the index from paddr[2]. Index 0 is capacity,
  // and index 1 holds no register, so a write there must be ignored.
  localparam logic [PADDR_W-1:0] CAP_ADDR    = {REG_CAPACITY, 2'b00};
  localparam logic [PADDR_W-1:0] UNUSED_ADDR = {~REG_CAPACITY, 2'b00};

  // Operation code 3 is not a command; the block must leave the queue alone.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Percent chance of an idle cycle on each side.
  localparam int IDLE_PCT   = 29;
  // The output hold-off must be long enough for the input side to back up.
  localparam int HOLD_LEN   = 200;
  // Cycles with nothing accepted on either side before the run is abandoned.
  localparam int STUCK_LIMIT = 4000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                item_valid = 1'b0;
  logic                item_stall;
  item_t               item_bus = '0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  result_t             result_bus;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  queue_from_two_stacks #(
    .MAX_DEPTH(DEPTH)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item_bus),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result_bus),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #4 clk = ~clk;

  // -------------------------------------------------------------------------
  // Mirror of the queue. Both stacks, their fill levels and the capacity
  // register are kept here and advanced once per accepted item, in the order
  // the block accepts them. Capacity only changes while the block is idle,
  // so the order of updates always matches the hardware.
  // -------------------------------------------------------------------------
  logic [31:0]      inbox_mirror [DEPTH];
  logic [31:0]      outbox_mirror [DEPTH];
  int unsigned      inbox_fill = 0;
  int unsigned      outbox_fill = 0;
  logic [CAP_W-1:0] capacity_mirror = CAPACITY_RESET;

  // Result items the block still owes, oldest first.
  result_t          replies_due [$];

  int unsigned      mismatch_count = 0;
  bit               gaps_on = 1'b1;
  bit               hold_req = 1'b0;
  int unsigned      hold_left = 0;
  int unsigned      stuck_cycles = 0;

  // When a pop or peek finds the outbox empty, the whole inbox is tipped onto it. The
  // newest inbox entry goes down first, which leaves the oldest one on top.
  function automatic void tip_inbox();
    if (outbox_fill != 0) return;
    while (inbox_fill != 0 && outbox_fill < DEPTH) begin
      inbox_fill--;
      outbox_mirror[outbox_fill] = inbox_mirror[inbox_fill];
      outbox_fill++;
    end
  endfunction

  function automatic result_t apply_queue_op(logic [1:0] op, logic [31:0] word);
    result_t     r;
    int unsigned limit;
    r = '0;
    // A capacity above the store depth is clamped to the depth.
    limit = (capacity_mirror > DEPTH) ? DEPTH : capacity_mirror;
    case (op)
      OP_PUSH: begin
        // Entries already held past a lowered capacity stay put; the push
        // is only refused.
        if (inbox_fill < limit) begin
          inbox_mirror[inbox_fill] = word;
          inbox_fill++;
        end else begin
          r.push_dropped = 1'b1;
        end
      end
      OP_POP: begin
        tip_inbox();
        if (outbox_fill != 0) outbox_fill--;
      end
      OP_PEEK: begin
        tip_inbox();
        if (outbox_fill != 0) r.front_value = outbox_mirror[outbox_fill - 1];
      end
      default: begin
      end
    endcase
    r.queue_empty = (inbox_fill == 0 && outbox_fill == 0);
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Sender side. Every call offers one item and returns at the falling edge
  // after it was taken. Valid is lowered there, but a following call raises
  // it again in the same step with a blocking write, so back-to-back items
  // keep valid high without a glitch.
  // -------------------------------------------------------------------------
  task automatic send_item(input logic [1:0] op, input logic [31:0] word);
    while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      item_valid = 1'b0;
      @(negedge clk);
    end
    item_valid = 1'b1;
    item_bus.operation = op;
    item_bus.value = word;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    replies_due.push_back(apply_queue_op(op, word));
    @(negedge clk);
    item_valid = 1'b0;
  endtask

  // Mostly uniform words, with the sign and magnitude extremes mixed in.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Two-phase register write: setup, then access until pready.
  task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr[2] == REG_CAPACITY) capacity_mirror = data[CAP_W-1:0];
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Hold the sender until every owed result has left the block. Every item
  // yields a result, so an empty list means the block is idle; the extra wait that follows
  // covers the last result register emptying.
  task automatic wait_drained();
    while (replies_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_capacity(input logic [31:0] cap);
    wait_drained();
    write_reg(CAP_ADDR, cap);
  endtask

  // -------------------------------------------------------------------------
  // Tests.
  // -------------------------------------------------------------------------

  // Empty-queue pops and peeks, the unused code on an empty and a filled
  // queue, word extremes in FIFO order, and a write to the unused register
  // index, which must leave capacity at its reset value of 16.
  task automatic test_empty_and_order();
    send_item(OP_POP, 32'h1234_5678);
    send_item(OP_PEEK, 32'hffff_ffff);
    send_item(OP_UNUSED, 32'h0);
    send_item(OP_PUSH, 32'h8000_0000);
    send_item(OP_PUSH, 32'h7fff_ffff);
    wait_drained();
    write_reg(UNUSED_ADDR, 32'h0);
    send_item(OP_PUSH, 32'h0000_0000);
    send_item(OP_PUSH, 32'hffff_ffff);
    send_item(OP_UNUSED, 32'hdead_beef);
    send_item(OP_PEEK, 32'h0);
    send_item(OP_POP, 32'h0);
    // A push while the outbox holds entries stays in the inbox until the
    // outbox is empty again.
    send_item(OP_PUSH, 32'h5555_5555);
    send_item(OP_PEEK, 32'h0);
    repeat (4) send_item(OP_POP, 32'h0);
  endtask

  // Lower the capacity under a partly filled inbox. Held entries survive,
  // new pushes are refused until a pop tips the inbox into the outbox.
  task automatic test_capacity_lowered();
    repeat (6) send_item(OP_PUSH, $urandom);
    set_capacity(3);
    send_item(OP_PUSH, 32'haaaa_aaaa);
    send_item(OP_POP, 32'h0);
    repeat (4) send_item(OP_PUSH, pick_word());
  endtask

  // Bursts of pushes and of pops or peeks, so the stacks run full and empty
  // again, with a sprinkling of arbitrary codes including the unused one.
  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned sent;
    int unsigned kind;
    int unsigned len;
    logic [1:0]  op;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(99);
      len = (kind < 85) ? $urandom_range(1, DEPTH + 3) : 1;
      for (int k = 0; k < len && sent < n_items; k++) begin
        if (kind < 45) op = OP_PUSH;
        else if (kind < 85) op = ($urandom_range(99) < 30) ? OP_PEEK : OP_POP;
        else op = 2'($urandom_range(3));
        send_item(op, pick_word());
        sent++;
      end
    end
  endtask

  // The receiver stops taking results for a long stretch while the sender
  // keeps offering, so the block backs up and stalls its input. Afterwards
  // the sender waits for every owed result before carrying on.
  task automatic test_output_hold();
    hold_req = 1'b1;
    test_random_traffic(40);
    wait_drained();
    test_random_traffic(10);
  endtask

  // -------------------------------------------------------------------------
  // Receiver side: random stalls, none at all while gaps are switched off,
  // and the long hold-off counted down here when requested.
  // -------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_LEN;
    end
    if (hold_left != 0) begin
      result_stall = 1'b1;
      hold_left--;
    end else if (gaps_on) begin
      result_stall = ($urandom_range(99) < IDLE_PCT);
    end else begin
      result_stall = 1'b0;
    end
  end

  // Each result item taken is matched against the oldest one owed.
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (replies_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: front %h empty %b dropped %b",
                   result_bus.front_value, result_bus.queue_empty,
                   result_bus.push_dropped);
      end else begin
        want = replies_due.pop_front();
        if (result_bus.front_value !== want.front_value ||
            result_bus.queue_empty !== want.queue_empty ||
            result_bus.push_dropped !== want.push_dropped) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: front %h/%h empty %b/%b dropped %b/%b (expected/actual)",
                     want.front_value, result_bus.front_value,
                     want.queue_empty, result_bus.queue_empty,
                     want.push_dropped, result_bus.push_dropped);
        end
      end
    end
  end

  // The run is abandoned once neither side has moved an item for too long.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(negedge clk);
    rst = 1'b0;

    test_empty_and_order();
    test_capacity_lowered();

    // Smallest real capacity, then zero, where every push is refused.
    set_capacity(1);
    test_random_traffic(100);
    set_capacity(0);
    test_random_traffic(60);

    // Largest register value, clamped to the store depth.
    set_capacity(31);
    test_random_traffic(120);
    set_capacity(2);
    test_random_traffic(100);

    // Full depth with both sides running flat out.
    set_capacity(DEPTH);
    gaps_on = 1'b0;
    test_random_traffic(120);
    gaps_on = 1'b1;

    set_capacity($urandom_range(1, 31));
    test_random_traffic(120);

    set_capacity(DEPTH);
    test_output_hold();

    while (replies_due.size() != 0) @(negedge clk);
    repeat (DEPTH + 8) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: queue_from_two_stacks.f
+incdir+hdl
hdl/qts_pkg.sv
hdl/qts_front.sv
hdl/qts_back.sv
hdl/queue_from_two_stacks.sv
test/queue_from_two_stacks_tb.sv
